// ===== rtl/core/aps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types, codes and name tables for the ALPN protocol selector.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam logic [15:0] MAX_LIST_BYTES = 16'd65535;

    localparam logic        STATUS_OK    = 1'b0;
    localparam logic        STATUS_FATAL = 1'b1;

    localparam logic [1:0]  PROTO_NONE   = 2'd0;
    localparam logic [1:0]  PROTO_HTTP11 = 2'd1;
    localparam logic [1:0]  PROTO_H2     = 2'd2;

    localparam logic [7:0]  H2_NAME_LEN     = 8'd2;
    localparam logic [7:0]  HTTP11_NAME_LEN = 8'd8;

    typedef struct packed {
        logic        status;
        logic [1:0]  protocol;
        logic [15:0] name_offset;
        logic [3:0]  name_length;
    } t_result;

    // "h2"
    function automatic logic [7:0] h2_name_byte(input logic idx);
        logic [7:0] b;
        case (idx)
            1'b0:    b = 8'h68;
            default: b = 8'h32;
        endcase
        return b;
    endfunction

    // "http/1.1"
    function automatic logic [7:0] http11_name_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h68;
            3'd1:    b = 8'h74;
            3'd2:    b = 8'h74;
            3'd3:    b = 8'h70;
            3'd4:    b = 8'h2F;
            3'd5:    b = 8'h31;
            3'd6:    b = 8'h2E;
            default: b = 8'h31;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/alpn_protocol_selector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Output: a registered result appears in the cycle after the request that ends the list.
// Throughput: one request per cycle while no result waits; the byte update is combinational.
// Stall: requests are held off only while a result sits unclaimed in the output register.
// Reset: synchronous, active low; clears the list state and empties the output register.
// ----------------------------------------------------------------------------
// alpn_protocol_selector_unit
// ALPN list parser: picks h2 over http/1.1 and reports its offset in the list.
// ----------------------------------------------------------------------------
module alpn_protocol_selector_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel: one list byte per request
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_list_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_empty_list,
    // result channel: one result per list
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_status,
    output logic [1:0]       o_protocol,
    output logic [15:0]      o_name_offset,
    output logic [3:0]       o_name_length
);
    import aps_pkg::*;

    logic    accept;
    logic    parse_done;
    logic    out_can_load;
    t_result parse_result;
    t_result out_result;

    // Take a request whenever the output register can absorb whatever it
    // produces; requests that do not end a list never need it, but keeping
    // one rule keeps the ready path short.
    assign o_in_ready = out_can_load;
    assign accept     = i_in_valid && o_in_ready;

    // Entry tracking, name matching and the final selection.
    aps_list_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_list_byte    (i_list_byte),
        .i_last_byte    (i_last_byte),
        .i_empty_list   (i_empty_list),
        .o_result       (parse_result),
        .o_result_valid (parse_done)
    );

    // Hold the result until the consumer takes it.
    aps_result_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (parse_done),
        .i_result   (parse_result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_status      = out_result.status;
    assign o_protocol    = out_result.protocol;
    assign o_name_offset = out_result.name_offset;
    assign o_name_length = out_result.name_length;

endmodule
`default_nettype wire

// ===== rtl/core/aps_list_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_list_parser
// Walks the list one byte per request, tracks entries and name matches, and
// forms the selection when the list ends.
// ----------------------------------------------------------------------------
module aps_list_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_list_byte,
    input  wire logic            i_last_byte,
    input  wire logic            i_empty_list,
    output aps_pkg::t_result     o_result,
    output logic                 o_result_valid
);
    import aps_pkg::*;

    logic [15:0] r_byte_position, n_byte_position;
    logic [7:0]  r_entry_remaining, n_entry_remaining;
    logic [7:0]  r_entry_length, n_entry_length;
    logic [15:0] r_entry_start, n_entry_start;
    logic        r_h2_match, n_h2_match;
    logic        r_h1_match, n_h1_match;
    logic        r_found_h2, n_found_h2;
    logic [15:0] r_h2_offset, n_h2_offset;
    logic        r_found_h1, n_found_h1;
    logic [15:0] r_h1_offset, n_h1_offset;
    logic        r_overflow, n_overflow;

    logic [7:0]  name_idx;
    logic [7:0]  remaining_dec;
    logic        list_end;

    assign name_idx      = r_entry_length - r_entry_remaining;
    assign remaining_dec = r_entry_remaining - 8'd1;
    assign list_end      = i_accept && (i_empty_list || i_last_byte);

    always_comb begin
        n_byte_position   = r_byte_position;
        n_entry_remaining = r_entry_remaining;
        n_entry_length    = r_entry_length;
        n_entry_start     = r_entry_start;
        n_h2_match        = r_h2_match;
        n_h1_match        = r_h1_match;
        n_found_h2        = r_found_h2;
        n_h2_offset       = r_h2_offset;
        n_found_h1        = r_found_h1;
        n_h1_offset       = r_h1_offset;
        n_overflow        = r_overflow;

        if (r_overflow || (r_byte_position >= MAX_LIST_BYTES)) begin
            // drop the byte and every later one
            n_overflow = 1'b1;
        end else begin
            if (r_entry_remaining == 8'd0) begin
                n_entry_length    = i_list_byte;
                n_entry_remaining = i_list_byte;
                n_entry_start     = r_byte_position + 16'd1;
                n_h2_match        = (i_list_byte == H2_NAME_LEN);
                n_h1_match        = (i_list_byte == HTTP11_NAME_LEN);
            end else begin
                n_h2_match = r_h2_match && (name_idx < 8'd2)
                             && (h2_name_byte(name_idx[0]) == i_list_byte);
                n_h1_match = r_h1_match && (name_idx < 8'd8)
                             && (http11_name_byte(name_idx[2:0]) == i_list_byte);
                n_entry_remaining = remaining_dec;
                if (remaining_dec == 8'd0) begin
                    if (n_h2_match) begin
                        n_found_h2  = 1'b1;
                        n_h2_offset = r_entry_start;
                    end else if (n_h1_match) begin
                        n_found_h1  = 1'b1;
                        n_h1_offset = r_entry_start;
                    end
                    n_h2_match = 1'b0;
                    n_h1_match = 1'b0;
                end
            end
            n_byte_position = r_byte_position + 16'd1;
        end
    end

    // selection from the state as it stands after this byte
    always_comb begin
        o_result.status      = STATUS_FATAL;
        o_result.protocol    = PROTO_NONE;
        o_result.name_offset = 16'd0;
        o_result.name_length = 4'd0;
        if (!i_empty_list && !n_overflow && (n_entry_remaining == 8'd0)) begin
            if (n_found_h2) begin
                o_result.status      = STATUS_OK;
                o_result.protocol    = PROTO_H2;
                o_result.name_offset = n_h2_offset;
                o_result.name_length = H2_NAME_LEN[3:0];
            end else if (n_found_h1) begin
                o_result.status      = STATUS_OK;
                o_result.protocol    = PROTO_HTTP11;
                o_result.name_offset = n_h1_offset;
                o_result.name_length = HTTP11_NAME_LEN[3:0];
            end
        end
    end

    assign o_result_valid = list_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || list_end) begin
            r_byte_position   <= '0;
            r_entry_remaining <= '0;
            r_entry_length    <= '0;
            r_entry_start     <= '0;
            r_h2_match        <= 1'b0;
            r_h1_match        <= 1'b0;
            r_found_h2        <= 1'b0;
            r_h2_offset       <= '0;
            r_found_h1        <= 1'b0;
            r_h1_offset       <= '0;
            r_overflow        <= 1'b0;
        end else if (i_accept) begin
            r_byte_position   <= n_byte_position;
            r_entry_remaining <= n_entry_remaining;
            r_entry_length    <= n_entry_length;
            r_entry_start     <= n_entry_start;
            r_h2_match        <= n_h2_match;
            r_h1_match        <= n_h1_match;
            r_found_h2        <= n_found_h2;
            r_h2_offset       <= n_h2_offset;
            r_found_h1        <= n_found_h1;
            r_h1_offset       <= n_h1_offset;
            r_overflow        <= n_overflow;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/aps_result_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_result_reg
// Output register: holds one result until taken, passes a new one on the
// cycle the old one leaves.
// ----------------------------------------------------------------------------
module aps_result_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  aps_pkg::t_result       i_result,
    output logic                   o_can_load,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output aps_pkg::t_result       o_result
);
    import aps_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ALPN protocol lists into alpn_protocol_selector_unit one byte per
// request, predicts each list's selection in a local parser copy and checks
// every result field against it, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import aps_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BACKLOG_CYCLES = 400;
    localparam int RANDOM_REQS    = 1900;

    // ways a generated list is closed off
    localparam int LIST_COMPLETE  = 0;
    localparam int LIST_CUT_SHORT = 1;
    localparam int LIST_ABORTED   = 2;

    // the two names the parser looks for, first byte in the top bits
    localparam logic [15:0] H2_TEXT     = "h2";
    localparam logic [63:0] HTTP11_TEXT = "http/1.1";

    typedef struct {
        logic [7:0] list_byte;
        logic       last_byte;
        logic       empty_list;
        logic       burst;      // no idle cycles after this request
    } t_alpn_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_list_byte;
    logic        i_last_byte;
    logic        i_empty_list;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_status;
    logic [1:0]  o_protocol;
    logic [15:0] o_name_offset;
    logic [3:0]  o_name_length;

    alpn_protocol_selector_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_list_byte   (i_list_byte),
        .i_last_byte   (i_last_byte),
        .i_empty_list  (i_empty_list),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_protocol    (o_protocol),
        .o_name_offset (o_name_offset),
        .o_name_length (o_name_length)
    );

    t_alpn_req   pending_reqs[$];
    t_alpn_req   next_req;
    logic [7:0]  list_bytes[$];
    t_result     selection_expected[$];

    int unsigned req_total;
    int unsigned results_seen;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;
    int unsigned cycle_count;
    int unsigned send_gap;
    int unsigned drain_gap;
    int unsigned backlog_hold;
    logic        backlog_done;
    logic        req_taken;

    // predicted parser state
    logic [15:0] p_position;
    logic [7:0]  p_remaining;
    logic [7:0]  p_length;
    logic [15:0] p_entry_start;
    logic        p_h2_live;
    logic        p_h1_live;
    logic        p_found_h2;
    logic [15:0] p_h2_offset;
    logic        p_found_h1;
    logic [15:0] p_h1_offset;
    logic        p_overflow;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------
    function automatic void clear_parse_state();
        p_position    = '0;
        p_remaining   = '0;
        p_length      = '0;
        p_entry_start = '0;
        p_h2_live     = 1'b0;
        p_h1_live     = 1'b0;
        p_found_h2    = 1'b0;
        p_h2_offset   = '0;
        p_found_h1    = 1'b0;
        p_h1_offset   = '0;
        p_overflow    = 1'b0;
    endfunction

    // Advance the parser by one accepted request; queue a selection on list end.
    task automatic parse_list_byte(input logic [7:0] b, input logic last,
                                   input logic empty);
        logic [7:0] idx;
        t_result    sel;
        sel = '{status: STATUS_FATAL, protocol: PROTO_NONE,
                name_offset: 16'd0, name_length: 4'd0};
        if (empty) begin
            // an empty list ends whatever was in progress, always fatal
            clear_parse_state();
            selection_expected.push_back(sel);
        end else begin
            if (p_overflow || p_position >= MAX_LIST_BYTES) begin
                // bound reached: drop this and every later byte of the list
                p_overflow = 1'b1;
            end else begin
                if (p_remaining == 8'd0) begin
                    p_length      = b;
                    p_remaining   = b;
                    p_entry_start = p_position + 16'd1;
                    p_h2_live     = (b == H2_NAME_LEN);
                    p_h1_live     = (b == HTTP11_NAME_LEN);
                end else begin
                    idx = p_length - p_remaining;
                    if (p_h2_live && (idx >= 8'd2 || H2_TEXT[8*(1-idx[0]) +: 8] != b))
                        p_h2_live = 1'b0;
                    if (p_h1_live &&
                        (idx >= 8'd8 || HTTP11_TEXT[8*(7-idx[2:0]) +: 8] != b))
                        p_h1_live = 1'b0;
                    p_remaining = p_remaining - 8'd1;
                    if (p_remaining == 8'd0) begin
                        if (p_h2_live) begin
                            p_found_h2  = 1'b1;
                            p_h2_offset = p_entry_start;
                        end else if (p_h1_live) begin
                            p_found_h1  = 1'b1;
                            p_h1_offset = p_entry_start;
                        end
                        p_h2_live = 1'b0;
                        p_h1_live = 1'b0;
                    end
                end
                p_position = p_position + 16'd1;
            end
            if (last) begin
                // h2 wins over http/1.1; a dangling entry or overflow is fatal
                if (!p_overflow && p_remaining == 8'd0) begin
                    if (p_found_h2) begin
                        sel = '{status: STATUS_OK, protocol: PROTO_H2,
                                name_offset: p_h2_offset, name_length: 4'd2};
                    end else if (p_found_h1) begin
                        sel = '{status: STATUS_OK, protocol: PROTO_HTTP11,
                                name_offset: p_h1_offset, name_length: 4'd8};
                    end
                end
                clear_parse_state();
                selection_expected.push_back(sel);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic int unsigned draw_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic push_req(input logic [7:0] b, input logic last, input logic empty,
                            input logic burst);
        t_alpn_req r;
        r.list_byte  = b;
        r.last_byte  = last;
        r.empty_list = empty;
        r.burst      = burst;
        pending_reqs.push_back(r);
        req_total++;
    endtask

    // Append a full "h2" or "http/1.1" entry to the list under construction.
    task automatic append_known_name(input logic is_h2);
        if (is_h2) begin
            list_bytes.push_back(H2_NAME_LEN);
            for (int k = 1; k >= 0; k--)
                list_bytes.push_back(H2_TEXT[8*k +: 8]);
        end else begin
            list_bytes.push_back(HTTP11_NAME_LEN);
            for (int k = 7; k >= 0; k--)
                list_bytes.push_back(HTTP11_TEXT[8*k +: 8]);
        end
    endtask

    task automatic append_random_entry(input int unsigned len_lo, input int unsigned len_hi);
        int unsigned len;
        len = $urandom_range(len_lo, len_hi);
        list_bytes.push_back(len[7:0]);
        for (int k = 0; k < len; k++)
            list_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Turn the list under construction into requests and clear it.
    task automatic emit_list(input int ending, input logic burst);
        int keep;
        keep = list_bytes.size();
        if (ending == LIST_CUT_SHORT && keep > 1)
            keep = $urandom_range(1, keep - 1);
        for (int k = 0; k < keep; k++)
            push_req(list_bytes[k], (ending != LIST_ABORTED) && (k == keep - 1), 1'b0, burst);
        if (ending == LIST_ABORTED)
            push_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, burst);
        list_bytes.delete();
    endtask

    task automatic build_random_list();
        int unsigned n_entries;
        int unsigned r;
        int unsigned kind;
        int          pos;
        n_entries = $urandom_range(1, 5);
        for (int e = 0; e < n_entries; e++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                append_known_name(1'b1);
            end else if (r < 45) begin
                append_known_name(1'b0);
            end else if (r < 60) begin
                // near miss: right length with one bit off, or an extra byte
                kind = $urandom_range(0, 2);
                if (kind == 2) begin
                    list_bytes.push_back(8'd3);
                    list_bytes.push_back(H2_TEXT[15:8]);
                    list_bytes.push_back(H2_TEXT[7:0]);
                    list_bytes.push_back(8'($urandom_range(0, 255)));
                end else begin
                    append_known_name(kind == 0);
                    pos = list_bytes.size() - $urandom_range(1, (kind == 0) ? 2 : 8);
                    list_bytes[pos] = list_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
                end
            end else if (r < 70) begin
                list_bytes.push_back(8'd0);
            end else if (r < 97) begin
                append_random_entry(1, 10);
            end else begin
                append_random_entry(100, 255);
            end
        end
        r = $urandom_range(0, 99);
        if (r < 4)
            emit_list(LIST_ABORTED, 1'b0);
        else if (r < 14)
            emit_list(LIST_CUT_SHORT, 1'b0);
        else
            emit_list(LIST_COMPLETE, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: fill the request queue, reset, wait for drain
    // ------------------------------------------------------------------
    initial begin
        int unsigned random_goal;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_list_byte    = 8'd0;
        i_last_byte    = 1'b0;
        i_empty_list   = 1'b0;
        i_out_ready    = 1'b0;
        req_total      = 0;
        results_seen   = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        cycle_count    = 0;
        send_gap       = 0;
        drain_gap      = 0;
        backlog_hold   = 0;
        backlog_done   = 1'b0;
        req_taken      = 1'b0;
        clear_parse_state();

        // empty list carrying a stray byte and last flag
        push_req(8'hFF, 1'b1, 1'b1, 1'b0);
        // lone h2, lone http/1.1
        append_known_name(1'b1);
        emit_list(LIST_COMPLETE, 1'b0);
        append_known_name(1'b0);
        emit_list(LIST_COMPLETE, 1'b0);
        // a single zero-length entry matches nothing
        list_bytes.push_back(8'd0);
        emit_list(LIST_COMPLETE, 1'b0);
        // list ends on a length byte: entry runs past the end
        list_bytes.push_back(8'hFF);
        emit_list(LIST_COMPLETE, 1'b0);
        // empty-list request in the middle of an h2 entry
        push_req(8'h02, 1'b0, 1'b0, 1'b0);
        push_req(8'h68, 1'b0, 1'b0, 1'b0);
        push_req(8'h00, 1'b0, 1'b1, 1'b0);

        random_goal = req_total + RANDOM_REQS;
        while (req_total < random_goal) begin
            if ($urandom_range(0, 99) < 3)
                push_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0);
            else
                build_random_list();
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_in_valid || selection_expected.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("alpn_protocol_selector_unit: match");
        else
            $display("alpn_protocol_selector_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        // hold the current request until it is taken
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                i_list_byte  <= next_req.list_byte;
                i_last_byte  <= next_req.last_byte;
                i_empty_list <= next_req.empty_list;
                i_in_valid   <= 1'b1;
                // back-to-back stretches now and then, else a random gap
                if (next_req.burst || (cycle_count % 700) < 150)
                    send_gap <= 0;
                else
                    send_gap <= draw_idle_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls plus one long backlog hold
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_result_ready
        int unsigned n;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (backlog_hold > 0) begin
            i_out_ready  <= 1'b0;
            backlog_hold <= backlog_hold - 1;
        end else if (!backlog_done && results_seen >= 15) begin
            // hold off long enough for a result to park and stall the input
            backlog_done <= 1'b1;
            backlog_hold <= BACKLOG_CYCLES - 1;
            i_out_ready  <= 1'b0;
        end else if (drain_gap > 0) begin
            drain_gap   <= drain_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            n = ((cycle_count % 900) < 200) ? 0 : draw_idle_len();
            if (n == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                drain_gap   <= n - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_sel;
        req_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (i_in_valid && o_in_ready)
                parse_list_byte(i_list_byte, i_last_byte, i_empty_list);
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                if (selection_expected.size() == 0) begin
                    $error("result with no list ended: status %0d protocol %0d",
                           o_status, o_protocol);
                    mismatch_count++;
                end else begin
                    exp_sel = selection_expected.pop_front();
                    if (o_status !== exp_sel.status) begin
                        $error("status: expected %0d, actual %0d", exp_sel.status, o_status);
                        mismatch_count++;
                    end
                    if (o_protocol !== exp_sel.protocol) begin
                        $error("protocol: expected %0d, actual %0d",
                               exp_sel.protocol, o_protocol);
                        mismatch_count++;
                    end
                    if (o_name_offset !== exp_sel.name_offset) begin
                        $error("name_offset: expected %0d, actual %0d",
                               exp_sel.name_offset, o_name_offset);
                        mismatch_count++;
                    end
                    if (o_name_length !== exp_sel.name_length) begin
                        $error("name_length: expected %0d, actual %0d",
                               exp_sel.name_length, o_name_length);
                        mismatch_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves for too long
    // ------------------------------------------------------------------
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("alpn_protocol_selector_unit: mismatch");
        $finish;
    end

endmodule
